// ===== sv/spvg_pkg.sv =====
// Shared types, constants and helpers for the star polygon vertex generator.
// Used by every module of the block; depends on nothing else.
package spvg_pkg;

    localparam int MAX_CORNERS  = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int ROT_W        = 20;
    localparam int ANGLE_W      = 32;
    localparam int CORDIC_START = 39797;

    localparam logic [3:0] REG_CORNER_COUNT = 4'd0;
    localparam logic [3:0] REG_CONVEX_MODE  = 4'd1;
    localparam logic [3:0] REG_TIP_RADIUS   = 4'd2;
    localparam logic [3:0] REG_BASE_RADIUS  = 4'd3;
    localparam logic [3:0] REG_TIP_ANGLE    = 4'd4;
    localparam logic [3:0] REG_BASE_ANGLE   = 4'd5;
    localparam logic [3:0] REG_ZOOM_PAIR    = 4'd6;
    localparam logic [3:0] REG_ROUND_PAIR   = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_ROT,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_EMIT
    } seq_state_t;

    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic signed [ANGLE_W-1:0] ang_t;

    // Values one CORDIC cell hands to the next.
    typedef struct packed {
        logic       valid;
        logic [1:0] quad;
        rot_t       x;
        rot_t       y;
        ang_t       z;
    } rot_stage_t;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
        logic signed [23:0] r;
        if (v > 34'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -34'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/spvg_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with its output register.
// Depends on spvg_pkg for the stage struct.
module spvg_cordic_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [4:0]            shift,
    input  logic [31:0]           atan,
    input  spvg_pkg::rot_stage_t  stage_in,
    output spvg_pkg::rot_stage_t  stage_out
);
    import spvg_pkg::*;

    rot_stage_t stage_reg, stage_next;
    rot_t       xs, ys;

    always_comb begin
        xs = stage_in.x >>> shift;
        ys = stage_in.y >>> shift;
        stage_next = stage_in;
        if (!stage_in.z[ANGLE_W-1]) begin
            stage_next.x = stage_in.x - ys;
            stage_next.y = stage_in.y + xs;
            stage_next.z = stage_in.z - $signed(atan);
        end else begin
            stage_next.x = stage_in.x + ys;
            stage_next.y = stage_in.y - xs;
            stage_next.z = stage_in.z + $signed(atan);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else begin
            stage_reg.valid <= stage_in.valid;
        end
        stage_reg.quad <= stage_next.quad;
        stage_reg.x    <= stage_next.x;
        stage_reg.y    <= stage_next.y;
        stage_reg.z    <= stage_next.z;
    end

    assign stage_out = stage_reg;

endmodule

// ===== sv/spvg_cordic_chain.sv =====
// Row of CORDIC cells with the quarter-turn fold in front and unfold behind.
// Depends on spvg_pkg and spvg_cordic_cell.
module spvg_cordic_chain (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [15:0]         angle,
    output logic                done,
    output spvg_pkg::rot_t      cos_out,
    output spvg_pkg::rot_t      sin_out
);
    import spvg_pkg::*;

    rot_stage_t links [CORDIC_STEPS+1];
    logic [15:0] shifted;
    logic [1:0]  quad;

    // Fold into [-1/8, 1/8) turn; the quadrant travels along with the data.
    always_comb begin
        shifted = angle + 16'h2000;
        quad = shifted[15:14];
        links[0].valid = start;
        links[0].quad  = quad;
        links[0].x     = ROT_W'(CORDIC_START);
        links[0].y     = '0;
        links[0].z     = $signed({angle - {quad, 14'b0}, 16'b0});
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        spvg_cordic_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift    (5'(k)),
            .atan     (ATAN_TAB[k]),
            .stage_in (links[k]),
            .stage_out(links[k+1])
        );
    end

    always_comb begin
        done = links[CORDIC_STEPS].valid;
        case (links[CORDIC_STEPS].quad)
            2'd0: begin
                cos_out = links[CORDIC_STEPS].x;
                sin_out = links[CORDIC_STEPS].y;
            end
            2'd1: begin
                cos_out = -links[CORDIC_STEPS].y;
                sin_out = links[CORDIC_STEPS].x;
            end
            2'd2: begin
                cos_out = -links[CORDIC_STEPS].x;
                sin_out = -links[CORDIC_STEPS].y;
            end
            default: begin
                cos_out = links[CORDIC_STEPS].y;
                sin_out = -links[CORDIC_STEPS].x;
            end
        endcase
    end

endmodule

// ===== sv/star_polygon_vertex_generator_top.sv =====
// Star polygon vertex generator: registers, vertex sequencer and output stage.
// Depends on spvg_pkg and spvg_cordic_chain.
// Flow: a restoring division forms half turn / n, then each emitted vertex passes
// one launch, 16 CORDIC cells, two multiply stages, sum and output load; in convex
// mode each skipped base corner passes through the step state alone. An output
// stall holds the walk. A new start item is taken only in idle, once the last vertex
// of the star has been loaded into the output register.
// Reset: synchronous, active low; configuration registers return to their defaults, no run.
module star_polygon_vertex_generator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // center_x [15:0], center_y [31:16]
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_x, point_y, ctrl_before_x, ctrl_before_y, ctrl_after_x, ctrl_after_y
    // (24 bits each from bit 0 up), point_index [149:144], zero pad [151:150]
    output logic [151:0] m_tdata,
    output logic [1:0]   m_tuser,   // has_controls [0], is_tip [1]
    output logic         m_tlast,   // last_point
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import spvg_pkg::*;

    seq_state_t state_reg, state_next;

    logic [5:0]  corner_count_reg;
    logic        convex_reg;
    logic [15:0] tip_radius_reg, base_radius_reg, tip_angle_reg, base_angle_reg;
    logic [31:0] zoom_reg, round_reg;

    logic [5:0]  n_reg;
    logic [3:0]  div_pos_reg;
    logic [5:0]  div_rem_reg;
    logic [15:0] div_quo_reg;
    logic [15:0] acc_q_reg;
    logic [5:0]  acc_r_reg;
    logic [5:0]  corner_reg;
    logic [5:0]  emit_reg;
    logic signed [15:0] cx_reg, cy_reg;

    rot_t cos_reg, sin_reg;
    logic [31:0] a_reg, b_reg;
    logic signed [32:0] e_reg;
    logic signed [33:0] f_reg;
    logic signed [55:0] pxp_reg, pyp_reg, txp_reg, typ_reg;
    logic signed [32:0] px_reg, py_reg;
    logic signed [31:0] tx_reg, ty_reg;

    logic [151:0] tdata_reg;
    logic [1:0]   tuser_reg;
    logic         tlast_reg, tvalid_reg;

    // Sequencer control outputs
    logic cordic_start, out_load, walk_advance, out_free;

    logic [5:0]  n_clamped;
    logic [6:0]  div_trial;
    logic [6:0]  acc_sum;
    logic        tip;
    logic        walk_done;
    logic [6:0]  total;
    logic [15:0] offset, angle;
    logic [15:0] radius;
    logic signed [15:0] rho;
    logic        cordic_done;
    rot_t        cordic_cos, cordic_sin;

    spvg_cordic_chain u_chain (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cordic_start),
        .angle  (angle),
        .done   (cordic_done),
        .cos_out(cordic_cos),
        .sin_out(cordic_sin)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !tvalid_reg || m_tready;

    always_comb begin
        if (corner_count_reg < 6'd3) begin
            n_clamped = 6'd3;
        end else if (corner_count_reg > 6'(MAX_CORNERS)) begin
            n_clamped = 6'(MAX_CORNERS);
        end else begin
            n_clamped = corner_count_reg;
        end
        div_trial = {div_rem_reg, (div_pos_reg == 4'd15)};
        acc_sum   = {1'b0, acc_r_reg} + {1'b0, div_rem_reg};
        tip       = corner_reg[0];
        walk_done = ({1'b0, corner_reg} + 7'd1) == {n_reg, 1'b0};
        total     = convex_reg ? {1'b0, n_reg} : {n_reg, 1'b0};
        offset    = tip ? tip_angle_reg : base_angle_reg;
        angle     = acc_q_reg + offset;
        radius    = tip ? tip_radius_reg : base_radius_reg;
        rho       = $signed(tip ? round_reg[31:16] : round_reg[15:0]);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_DIV;
            ST_DIV:  if (div_pos_reg == 4'd0) state_next = ST_STEP;
            ST_STEP: begin
                if (!tip && convex_reg) begin
                    state_next = walk_done ? ST_IDLE : ST_STEP;
                end else begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:  if (cordic_done) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SUM;
            ST_SUM:  state_next = ST_EMIT;
            ST_EMIT: if (out_free) state_next = walk_done ? ST_IDLE : ST_STEP;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        cordic_start = 1'b0;
        out_load     = 1'b0;
        walk_advance = 1'b0;
        case (state_reg)
            ST_STEP: begin
                cordic_start = !(!tip && convex_reg);
                walk_advance = !tip && convex_reg;
            end
            ST_EMIT: begin
                out_load     = out_free;
                walk_advance = out_free;
            end
            default: begin
                cordic_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            corner_count_reg <= 6'd5;
            convex_reg       <= 1'b0;
            tip_radius_reg   <= 16'd800;
            base_radius_reg  <= 16'd400;
            tip_angle_reg    <= 16'd0;
            base_angle_reg   <= 16'd0;
            zoom_reg         <= 32'h01000100;
            round_reg        <= 32'd0;
            tvalid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_CORNER_COUNT: corner_count_reg <= cfg_data[5:0];
                    REG_CONVEX_MODE:  convex_reg       <= cfg_data[0];
                    REG_TIP_RADIUS:   tip_radius_reg   <= cfg_data[15:0];
                    REG_BASE_RADIUS:  base_radius_reg  <= cfg_data[15:0];
                    REG_TIP_ANGLE:    tip_angle_reg    <= cfg_data[15:0];
                    REG_BASE_ANGLE:   base_angle_reg   <= cfg_data[15:0];
                    REG_ZOOM_PAIR:    zoom_reg         <= cfg_data;
                    REG_ROUND_PAIR:   round_reg        <= cfg_data;
                    default:          round_reg        <= round_reg;
                endcase
            end
            if (out_load) begin
                tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            cx_reg      <= $signed(s_tdata[15:0]);
            cy_reg      <= $signed(s_tdata[31:16]);
            n_reg       <= n_clamped;
            div_pos_reg <= 4'd15;
            div_rem_reg <= 6'd0;
            div_quo_reg <= 16'd0;
            corner_reg  <= 6'd0;
            emit_reg    <= 6'd0;
        end
        // Restoring division of a half turn by n, one quotient bit a cycle.
        if (state_reg == ST_DIV) begin
            if (div_trial >= {1'b0, n_reg}) begin
                div_rem_reg <= 6'(div_trial - {1'b0, n_reg});
                div_quo_reg <= {div_quo_reg[14:0], 1'b1};
                acc_q_reg   <= {div_quo_reg[14:0], 1'b1};
                acc_r_reg   <= 6'(div_trial - {1'b0, n_reg});
            end else begin
                div_rem_reg <= div_trial[5:0];
                div_quo_reg <= {div_quo_reg[14:0], 1'b0};
                acc_q_reg   <= {div_quo_reg[14:0], 1'b0};
                acc_r_reg   <= div_trial[5:0];
            end
            div_pos_reg <= div_pos_reg - 4'd1;
        end
        // Corner angle floor((i+1) * half / n) kept as quotient and remainder.
        if (walk_advance) begin
            corner_reg <= corner_reg + 6'd1;
            if (acc_sum >= {1'b0, n_reg}) begin
                acc_q_reg <= acc_q_reg + div_quo_reg + 16'd1;
                acc_r_reg <= 6'(acc_sum - {1'b0, n_reg});
            end else begin
                acc_q_reg <= acc_q_reg + div_quo_reg;
                acc_r_reg <= acc_sum[5:0];
            end
        end
        if (state_reg == ST_ROT && cordic_done) begin
            cos_reg <= cordic_cos;
            sin_reg <= cordic_sin;
        end
        if (state_reg == ST_MUL1) begin
            a_reg <= zoom_reg[31:16] * radius;
            b_reg <= zoom_reg[15:0] * radius;
            e_reg <= rho * $signed({1'b0, zoom_reg[15:0]});
            f_reg <= -(34'(rho) * $signed({1'b0, zoom_reg[31:16]}));
        end
        if (state_reg == ST_MUL2) begin
            pxp_reg <= $signed({1'b0, a_reg}) * cos_reg;
            pyp_reg <= $signed({1'b0, b_reg}) * sin_reg;
            txp_reg <= e_reg * sin_reg;
            typ_reg <= f_reg * cos_reg;
        end
        if (state_reg == ST_SUM) begin
            px_reg <= 33'(cx_reg) + 33'((pxp_reg + 56'sd8388608) >>> 24);
            py_reg <= 33'(cy_reg) + 33'((pyp_reg + 56'sd8388608) >>> 24);
            tx_reg <= 32'((txp_reg + 56'sd8388608) >>> 24);
            ty_reg <= 32'((typ_reg + 56'sd8388608) >>> 24);
        end
        if (out_load) begin
            emit_reg <= emit_reg + 6'd1;
            tdata_reg[23:0]    <= sat24(34'(px_reg));
            tdata_reg[47:24]   <= sat24(34'(py_reg));
            tdata_reg[149:144] <= emit_reg;
            tdata_reg[151:150] <= 2'b00;
            if (rho != 16'sd0) begin
                tdata_reg[71:48]   <= sat24(34'(px_reg) - 34'(tx_reg));
                tdata_reg[95:72]   <= sat24(34'(py_reg) - 34'(ty_reg));
                tdata_reg[119:96]  <= sat24(34'(px_reg) + 34'(tx_reg));
                tdata_reg[143:120] <= sat24(34'(py_reg) + 34'(ty_reg));
            end else begin
                tdata_reg[143:48]  <= '0;
            end
            tuser_reg <= {tip, (rho != 16'sd0)};
            tlast_reg <= ({1'b0, emit_reg} + 7'd1) == total;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

`ifndef NO_ASSERTIONS
    // A finished vertex never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while pending");

    // The angle remainder stays below n while the corners are walked.
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP || state_reg == ST_EMIT) |-> (acc_r_reg < n_reg))
        else $error("angle remainder out of range");

    // The corner walk never runs past 2n corners.
    a_corner_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> ({1'b0, corner_reg} < {n_reg, 1'b0}))
        else $error("corner index beyond the star");

    // The rotation wait is entered only after a rotation was launched.
    a_cordic_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_ROT) |-> $past(cordic_start))
        else $error("rotation wait entered without a launch");
`endif

endmodule

// ===== dv/star_polygon_vertex_generator_top_tb.sv =====
// Testbench for the star polygon vertex generator: drives start items and
// register writes, predicts every vertex and compares each output transfer.
// Depends on spvg_pkg and the block's RTL.
`timescale 1ns / 100ps

module star_polygon_vertex_generator_top_tb;
    import spvg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [23:0] px, py, bx, by, ax, ay;
        logic        has_ctrl;
        logic        tip;
        logic [5:0]  idx;
        logic        last;
    } vertex_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [3:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    // Predictor copy of the register file.
    logic [5:0]  corner_count;
    logic        convex_mode;
    logic [15:0] tip_radius, base_radius, tip_angle, base_angle;
    logic [31:0] zoom_pair, roundness_pair;

    vertex_t     expected_vertices[$];
    int          error_count = 0;
    int          vertex_count = 0;
    int          start_count = 0;
    int          idle_cycles = 0;
    int          ready_hold = 0;
    bit          stall_enable = 1'b1;

    star_polygon_vertex_generator_top u_top (.*);

    always #5 aclk = ~aclk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint asr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint round_q4(longint v);
        return (v + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic logic [23:0] clip24(longint v);
        if (v > 8388607) return 24'h7FFFFF;
        if (v < -8388608) return 24'h800000;
        return v[23:0];
    endfunction

    // Rotation-mode CORDIC on a 32-bit-per-turn angle, 16 fraction bits out.
    task automatic trig(input logic [31:0] a, output longint c, output longint s);
        logic [1:0]  q;
        logic [31:0] d;
        longint      x, y, z, nx;
        q = 2'((a + 32'h20000000) >> 30);
        d = a - {q, 30'd0};
        z = longint'($signed(d));
        x = CORDIC_START;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (z >= 0) begin
                nx = x - asr(y, k); y = y + asr(x, k); z = z - ATAN_TAB[k];
            end else begin
                nx = x + asr(y, k); y = y - asr(x, k); z = z + ATAN_TAB[k];
            end
            x = nx;
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_star(input logic [15:0] cx_bits, input logic [15:0] cy_bits);
        int          n, total, emitted;
        bit          tip;
        logic [15:0] ang;
        longint      cx, cy, zx, zy, rho, r, c, s, px, py, tx, ty;
        vertex_t     v;
        n = corner_count;
        if (n < 3) n = 3;
        if (n > MAX_CORNERS) n = MAX_CORNERS;
        total = convex_mode ? n : 2 * n;
        cx = longint'($signed(cx_bits));
        cy = longint'($signed(cy_bits));
        zx = zoom_pair[31:16];
        zy = zoom_pair[15:0];
        emitted = 0;
        for (int i = 0; i < 2 * n; i++) begin
            tip = i[0];
            if (!tip && convex_mode) continue;
            ang = 16'(((i + 1) * 32768) / n) + (tip ? tip_angle : base_angle);
            trig({ang, 16'd0}, c, s);
            r = tip ? tip_radius : base_radius;
            rho = longint'($signed(tip ? roundness_pair[31:16] : roundness_pair[15:0]));
            px = cx + round_q4(zx * r * c);
            py = cy + round_q4(zy * r * s);
            v = '0;
            v.px = clip24(px);
            v.py = clip24(py);
            if (rho != 0) begin
                tx = round_q4(rho * zy * s);
                ty = round_q4(-rho * zx * c);
                v.bx = clip24(px - tx);
                v.by = clip24(py - ty);
                v.ax = clip24(px + tx);
                v.ay = clip24(py + ty);
                v.has_ctrl = 1'b1;
            end
            v.tip = tip;
            v.idx = 6'(emitted);
            v.last = (emitted + 1 == total);
            expected_vertices.insert(expected_vertices.size(), v);
            emitted++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        error_count++;
        $display("MISMATCH vertex %0d %s: got %h expected %h", vertex_count, what, got, want);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (expected_vertices.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            REG_CORNER_COUNT: corner_count   = value[5:0];
            REG_CONVEX_MODE:  convex_mode    = value[0];
            REG_TIP_RADIUS:   tip_radius     = value[15:0];
            REG_BASE_RADIUS:  base_radius    = value[15:0];
            REG_TIP_ANGLE:    tip_angle      = value[15:0];
            REG_BASE_ANGLE:   base_angle     = value[15:0];
            REG_ZOOM_PAIR:    zoom_pair      = value;
            REG_ROUND_PAIR:   roundness_pair = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_center(input logic [15:0] cx, input logic [15:0] cy);
        s_tvalid <= 1'b1;
        s_tdata  <= {cy, cx};
        do @(posedge aclk); while (!s_tready);
        predict_star(cx, cy);
        start_count++;
        s_tvalid <= 1'b0;
        repeat (1 + gap_length()) @(posedge aclk);
    endtask

    task automatic write_random_settings(input bit small_n);
        write_reg(REG_CORNER_COUNT, small_n ? $urandom_range(0, 8) : $urandom_range(0, 63));
        write_reg(REG_CONVEX_MODE, $urandom_range(0, 1));
        write_reg(REG_TIP_RADIUS, $urandom);
        write_reg(REG_BASE_RADIUS, $urandom);
        write_reg(REG_TIP_ANGLE, $urandom);
        write_reg(REG_BASE_ANGLE, $urandom);
        write_reg(REG_ZOOM_PAIR, $urandom);
        write_reg(REG_ROUND_PAIR, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
    endtask

    task automatic test_reset_defaults();
        send_center(16'h0000, 16'h0000);
        send_center(16'h7FFF, 16'h8000);
        wait_idle();
    endtask

    task automatic test_extremes();
        write_reg(REG_CORNER_COUNT, 32'd0);    // clamped up to three
        write_reg(REG_CONVEX_MODE, 1);
        write_reg(REG_TIP_RADIUS, 16'hFFFF);
        write_reg(REG_BASE_RADIUS, 16'hFFFF);
        write_reg(REG_TIP_ANGLE, 16'hFFFF);
        write_reg(REG_BASE_ANGLE, 16'h8000);
        write_reg(REG_ZOOM_PAIR, 32'hFFFF_FFFF);
        write_reg(REG_ROUND_PAIR, 32'h8000_7FFF);
        send_center(16'h7FFF, 16'h7FFF);
        send_center(16'h8000, 16'h8000);
        wait_idle();
        write_reg(REG_CORNER_COUNT, 32'd63);   // clamped down to the maximum
        write_reg(REG_CONVEX_MODE, 0);
        write_reg(REG_ROUND_PAIR, 32'h0000_0001);
        send_center(16'h1234, 16'hEDCB);
        wait_idle();
        // Zero radius and zero zoom put every vertex on the center.
        write_reg(REG_CORNER_COUNT, 32'd3);
        write_reg(REG_TIP_RADIUS, 0);
        write_reg(REG_ZOOM_PAIR, 0);
        write_reg(REG_ROUND_PAIR, 32'hFFFF_0000);
        write_reg(4'd12, 32'hDEAD_BEEF);      // index past the register list
        send_center(16'h8000, 16'h7FFF);
        wait_idle();
    endtask

    task automatic test_random_stars(input int items);
        for (int k = 0; k < items; k++) begin
            if (k % 10 == 0) begin
                wait_idle();
                stall_enable = (k % 40 != 20);
                write_random_settings(k % 60 != 0);
            end
            send_center(16'($urandom), 16'($urandom));
        end
        wait_idle();
    endtask

    // Result side: random stalls and field-by-field compare.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                vertex_t got, want;
                got.px = m_tdata[23:0];    got.py = m_tdata[47:24];
                got.bx = m_tdata[71:48];   got.by = m_tdata[95:72];
                got.ax = m_tdata[119:96];  got.ay = m_tdata[143:120];
                got.idx = m_tdata[149:144];
                got.has_ctrl = m_tuser[0]; got.tip = m_tuser[1];
                got.last = m_tlast;
                if (expected_vertices.size() == 0) begin
                    report_mismatch("unexpected vertex", got.px, 24'h0);
                end else begin
                    want = expected_vertices[0];
                    expected_vertices.delete(0);
                    if (got.px != want.px) report_mismatch("point_x", got.px, want.px);
                    if (got.py != want.py) report_mismatch("point_y", got.py, want.py);
                    if (got.bx != want.bx) report_mismatch("ctrl_before_x", got.bx, want.bx);
                    if (got.by != want.by) report_mismatch("ctrl_before_y", got.by, want.by);
                    if (got.ax != want.ax) report_mismatch("ctrl_after_x", got.ax, want.ax);
                    if (got.ay != want.ay) report_mismatch("ctrl_after_y", got.ay, want.ay);
                    if (got.has_ctrl != want.has_ctrl)
                        report_mismatch("has_controls", 24'(got.has_ctrl), 24'(want.has_ctrl));
                    if (got.tip != want.tip)
                        report_mismatch("is_tip", 24'(got.tip), 24'(want.tip));
                    if (got.idx != want.idx)
                        report_mismatch("point_index", 24'(got.idx), 24'(want.idx));
                    if (got.last != want.last)
                        report_mismatch("last_point", 24'(got.last), 24'(want.last));
                end
                vertex_count++;
                if (stall_enable) ready_hold = gap_length();
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d vertices pending", expected_vertices.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        corner_count = 6'd5;
        convex_mode = 1'b0;
        tip_radius = 16'd800;
        base_radius = 16'd400;
        tip_angle = 16'd0;
        base_angle = 16'd0;
        zoom_pair = 32'h0100_0100;
        roundness_pair = 32'd0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_reset_defaults();
        test_extremes();
        test_random_stars(380);
        $display("Covered %0d start items and %0d vertices over random settings,",
                 start_count, vertex_count);
        $display("including clamped corner counts, convex mode and saturated coordinates.");
        if (error_count == 0 && expected_vertices.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
